// ===== hw/rtl/bpc_pkg.sv =====
// Shared constants, types and register codes of the button press classifier.
`timescale 1ns / 1ps

package bpc_pkg;

   // Number of buttons; fixed by the mode, plus and minus fields of a request.
   localparam int BUTTONS = 3;
   localparam int BIDX_W  = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

   // Default width of the tick counter and of the stored press ticks.
   localparam int TICK_BITS_DEF = 16;

   // Configuration register width and reset values.
   localparam int                CFG_W              = 16;
   localparam logic [CFG_W-1:0]  LONG_PRESS_RESET   = 16'd44;
   localparam logic [CFG_W-1:0]  REPEAT_PERIOD_RESET = 16'd8;

   // Configuration register indexes.
   localparam int               CSR_IDX_W           = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_PERIOD    = 2'd1;

   // Event bits of one button.
   localparam int             EV_W      = 4;
   localparam logic [EV_W-1:0] EV_NONE   = 4'b0000;
   localparam logic [EV_W-1:0] EV_DOWN   = 4'b0001;
   localparam logic [EV_W-1:0] EV_REPEAT = 4'b0010;
   localparam logic [EV_W-1:0] EV_SHORT  = 4'b0100;
   localparam logic [EV_W-1:0] EV_LONG   = 4'b1000;

   typedef logic [EV_W-1:0] event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELAP,
      ST_EVAL,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

// ===== hw/rtl/bpc_req_if.sv =====
// Request channel: one tick with the pressed level of every button.
`timescale 1ns / 1ps

interface bpc_req_if;
   logic valid;
   logic ready;
   logic mode_pressed;
   logic plus_pressed;
   logic minus_pressed;

   modport source (output valid, output mode_pressed, output plus_pressed,
                   output minus_pressed, input ready);
   modport sink   (input valid, input mode_pressed, input plus_pressed,
                   input minus_pressed, output ready);
endinterface

// ===== hw/rtl/bpc_rsp_if.sv =====
// Response channel: per-button events and the all-released flag of one tick.
`timescale 1ns / 1ps

interface bpc_rsp_if
   import bpc_pkg::*;
;
   logic       valid;
   logic       ready;
   event_type  mode_events;
   event_type  plus_events;
   event_type  minus_events;
   logic       all_released;

   modport source (output valid, output mode_events, output plus_events,
                   output minus_events, output all_released, input ready);
   modport sink   (input valid, input mode_events, input plus_events,
                   input minus_events, input all_released, output ready);
endinterface

// ===== hw/rtl/bpc_csr_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface bpc_csr_if
   import bpc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/button_press_classifier_unit.sv =====
// Top level of the button press classifier: sequencer and shared remainder unit.
`timescale 1ns / 1ps
//
// Usage
//   req carries one tick: the pressed level of the mode, plus and minus buttons.
//   rsp returns one word per tick: four event bits per button (down, repeat,
//   short, long) and a flag that is set when no button is held afterwards.
//   csr writes register 0 (long press ticks) or 1 (repeat period); other
//   indexes are ignored. csr is always ready; write it only while idle.
// Sequence
//   Each button of a tick passes through an elapsed step and an evaluate step,
//   then the word is posted; a held button past its long press count, with a
//   nonzero repeat period, also runs the repeat check before the next button.
//   The repeat check is a restoring remainder unit, one bit per cycle, shared
//   by all buttons; it sets the worst case. req is ready only when idle.
// Reset and stall
//   reset clears the tick counter, the held flags and the press ticks and
//   loads the registers with 44 and 8. A finished word waits in the output
//   register while the next tick is accepted; the sequencer holds before
//   posting the following word until rsp takes the waiting one.
//
module button_press_classifier_unit
   import bpc_pkg::*;
#(
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   bpc_req_if.sink       req,
   bpc_rsp_if.source     rsp,
   bpc_csr_if.sink       csr
);

   localparam int CW    = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;
   localparam int CNT_W = $clog2(TICK_BITS + 1);
   localparam logic [BIDX_W-1:0] LAST_BTN = BIDX_W'(BUTTONS - 1);

   state_type                          state_ff, state_in;
   logic [BIDX_W-1:0]                  btn_ff, btn_in;
   logic [BUTTONS-1:0]                 level_ff, level_in;
   logic [BUTTONS-1:0]                 held_ff, held_in;
   logic [TICK_BITS-1:0]               tick_ff, tick_in;
   logic [TICK_BITS-1:0]               press_ff [BUTTONS];
   logic [TICK_BITS-1:0]               press_in [BUTTONS];
   logic [TICK_BITS-1:0]               elap_ff, elap_in;
   logic [BUTTONS-1:0][EV_W-1:0]       ev_ff, ev_in;
   logic [CFG_W-1:0]                   long_ff, long_in;
   logic [CFG_W-1:0]                   period_ff, period_in;
   logic [TICK_BITS-1:0]               shift_ff, shift_in;
   logic [CFG_W-1:0]                   rem_ff, rem_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [BUTTONS-1:0][EV_W-1:0]       out_ev_ff, out_ev_in;
   logic                               out_rel_ff, out_rel_in;

   logic [TICK_BITS-1:0] elapsed;
   logic [CFG_W:0]       cand;
   logic [CFG_W:0]       cand_sub;
   logic                 done_btn;
   event_type            ev_cur;

   assign req.ready        = (state_ff == ST_IDLE);
   assign csr.ready        = 1'b1;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.mode_events  = out_ev_ff[0];
   assign rsp.plus_events  = out_ev_ff[1];
   assign rsp.minus_events = out_ev_ff[2];
   assign rsp.all_released = out_rel_ff;

   assign elapsed  = tick_ff - press_ff[btn_ff];
   assign cand     = {rem_ff, shift_ff[TICK_BITS-1]};
   assign cand_sub = cand - {1'b0, period_ff};

   always_comb begin
      state_in     = state_ff;
      btn_in       = btn_ff;
      level_in     = level_ff;
      held_in      = held_ff;
      tick_in      = tick_ff;
      press_in     = press_ff;
      elap_in      = elap_ff;
      ev_in        = ev_ff;
      long_in      = long_ff;
      period_in    = period_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      out_ev_in    = out_ev_ff;
      out_rel_in   = out_rel_ff;
      done_btn     = 1'b0;
      ev_cur       = EV_NONE;

      if (csr.valid) begin
         unique case (csr.index)
            CSR_LONG_PRESS_TICKS: long_in   = csr.data;
            CSR_REPEAT_PERIOD:    period_in = csr.data;
            default: ;
         endcase
      end

      // drop the word once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               level_in = {req.minus_pressed, req.plus_pressed, req.mode_pressed};
               tick_in  = tick_ff + 1'b1;
               btn_in   = '0;
               state_in = ST_ELAP;
            end
         end
         ST_ELAP: begin
            elap_in  = elapsed;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (level_ff[btn_ff]) begin
               if (!held_ff[btn_ff]) begin
                  held_in[btn_ff]  = 1'b1;
                  press_in[btn_ff] = tick_ff;
                  ev_cur           = EV_DOWN;
                  done_btn         = 1'b1;
               end else if (CW'(elap_ff) == CW'(long_ff)) begin
                  ev_cur   = EV_LONG | EV_REPEAT;
                  done_btn = 1'b1;
               end else if (CW'(elap_ff) > CW'(long_ff) && period_ff != '0) begin
                  // start the remainder of (elapsed - long) by the period
                  shift_in = elap_ff - TICK_BITS'(long_ff);
                  rem_in   = '0;
                  cnt_in   = CNT_W'(TICK_BITS);
                  state_in = ST_DIV;
               end else begin
                  done_btn = 1'b1;
               end
            end else begin
               if (held_ff[btn_ff] && CW'(elap_ff) < CW'(long_ff)) begin
                  ev_cur = EV_SHORT;
               end
               held_in[btn_ff] = 1'b0;
               done_btn        = 1'b1;
            end
         end
         ST_DIV: begin
            if (!cand_sub[CFG_W]) begin
               rem_in = cand_sub[CFG_W-1:0];
            end else begin
               rem_in = cand[CFG_W-1:0];
            end
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               ev_cur   = (rem_in == '0) ? EV_REPEAT : EV_NONE;
               done_btn = 1'b1;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               out_ev_in    = ev_ff;
               out_rel_in   = ~|held_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // advance to the next button or post the word
      if (done_btn) begin
         ev_in[btn_ff] = ev_cur;
         if (btn_ff == LAST_BTN) begin
            state_in = ST_OUT;
         end else begin
            btn_in   = btn_ff + 1'b1;
            state_in = ST_ELAP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         btn_ff       <= '0;
         held_ff      <= '0;
         tick_ff      <= '0;
         long_ff      <= LONG_PRESS_RESET;
         period_ff    <= REPEAT_PERIOD_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < BUTTONS; i++) begin
            press_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         btn_ff       <= btn_in;
         held_ff      <= held_in;
         tick_ff      <= tick_in;
         long_ff      <= long_in;
         period_ff    <= period_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         press_ff     <= press_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff   <= level_in;
      elap_ff    <= elap_in;
      ev_ff      <= ev_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      out_ev_ff  <= out_ev_in;
      out_rel_ff <= out_rel_in;
   end

endmodule

// ===== dv/tb_button_press_classifier_unit.sv =====
// Testbench for the button press classifier: random button traffic checked against a predictor.
`timescale 1ns / 1ps

module tb_button_press_classifier_unit;
   import bpc_pkg::*;

   localparam int RUN_LIMIT      = 2_000_000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int HOLDOFF_CYCLES = 600;
   localparam int PHASE_TICKS    = 150;
   localparam int MAX_REPORTS    = 10;

   // Index outside the register map; the block ignores writes to it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd2;

   typedef logic [BUTTONS-1:0] levels_type;

   typedef struct {
      event_type mode_ev;
      event_type plus_ev;
      event_type minus_ev;
      logic      all_rel;
   } tick_events_type;

   logic clock;
   logic reset;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();
   bpc_csr_if csr_ch ();

   button_press_classifier_unit DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // Button levels waiting to be sent and event words waiting to come back.
   levels_type      pending_levels [$];
   tick_events_type predicted_events [$];

   int   send_idle_pct;
   int   rcv_idle_pct;
   logic holdoff_go = 1'b0;
   logic rsp_hold;
   int   mismatch_count = 0;
   int   cycle_count = 0;

   // Predictor state and its copy of the timing registers.
   logic [TICK_BITS_DEF-1:0] tick_now;
   logic [TICK_BITS_DEF-1:0] press_at [BUTTONS];
   logic                     held_now [BUTTONS];
   logic [CFG_W-1:0]         long_ticks;
   logic [CFG_W-1:0]         rep_period;

   function automatic event_type button_events(int b, logic pressed);
      event_type                ev;
      logic [TICK_BITS_DEF-1:0] elapsed;
      ev = EV_NONE;
      elapsed = tick_now - press_at[b];
      if (pressed) begin
         if (!held_now[b]) begin
            held_now[b] = 1'b1;
            press_at[b] = tick_now;
            ev = EV_DOWN;
         end else if (elapsed == long_ticks) begin
            ev = EV_LONG | EV_REPEAT;
         end else if (elapsed > long_ticks && rep_period != 0 &&
                      (elapsed - long_ticks) % rep_period == 0) begin
            ev = EV_REPEAT;
         end
      end else begin
         if (held_now[b] && elapsed < long_ticks) begin
            ev = EV_SHORT;
         end
         held_now[b] = 1'b0;
      end
      return ev;
   endfunction

   function automatic void predict_tick(levels_type lv);
      tick_events_type r;
      tick_now = tick_now + 1'b1;
      r.mode_ev  = button_events(0, lv[0]);
      r.plus_ev  = button_events(1, lv[1]);
      r.minus_ev = button_events(2, lv[2]);
      r.all_rel  = !(held_now[0] || held_now[1] || held_now[2]);
      predicted_events.push_back(r);
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: mismatch: %s", $time, msg);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_button_press_classifier_unit: FAIL");
         $finish;
      end
   end

   // Driver: hold a word until it is taken, then offer the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_tick({req_ch.minus_pressed, req_ch.plus_pressed, req_ch.mode_pressed});
            pending_levels.delete(0);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_levels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid         <= 1'b1;
               req_ch.mode_pressed  <= pending_levels[0][0];
               req_ch.plus_pressed  <= pending_levels[0][1];
               req_ch.minus_pressed <= pending_levels[0][2];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every taken word with the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      tick_events_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_events.size() == 0) begin
               flag_mismatch($sformatf("word with nothing predicted: %h %h %h %b",
                  rsp_ch.mode_events, rsp_ch.plus_events, rsp_ch.minus_events,
                  rsp_ch.all_released));
            end else begin
               want = predicted_events.pop_front();
               if (rsp_ch.mode_events !== want.mode_ev ||
                   rsp_ch.plus_events !== want.plus_ev ||
                   rsp_ch.minus_events !== want.minus_ev ||
                   rsp_ch.all_released !== want.all_rel) begin
                  flag_mismatch($sformatf(
                     "mode %h/%h plus %h/%h minus %h/%h released %b/%b (exp/act)",
                     want.mode_ev, rsp_ch.mode_events, want.plus_ev, rsp_ch.plus_events,
                     want.minus_ev, rsp_ch.minus_events, want.all_rel,
                     rsp_ch.all_released));
               end
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // Long receiver hold-off so the block backs up and stalls its input.
   initial begin : rsp_holdoff
      rsp_hold = 1'b0;
      while (!holdoff_go) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic push_tick(levels_type lv);
      pending_levels.push_back(lv);
   endtask

   task automatic push_hold(levels_type lv, int n);
      repeat (n) push_tick(lv);
   endtask

   task automatic drain_words();
      while (pending_levels.size() != 0 || predicted_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_LONG_PRESS_TICKS) begin
         long_ticks = val;
      end else if (idx == CSR_REPEAT_PERIOD) begin
         rep_period = val;
      end
   endtask

   task automatic set_timing(logic [CFG_W-1:0] lp, logic [CFG_W-1:0] rp);
      drain_words();
      write_csr(CSR_LONG_PRESS_TICKS, lp);
      write_csr(CSR_REPEAT_PERIOD, rp);
   endtask

   // Press and release each button for spans near the long press and repeat
   // points, with occasional bounce on top.
   task automatic push_button_traffic(int n);
      int         left [BUTTONS];
      logic       lvl [BUTTONS];
      levels_type word;
      int         lp;
      int         rp;
      int         cap;
      int         d;
      lp = long_ticks;
      rp = rep_period;
      cap = lp + 4 * rp + 3;
      if (cap > 120) cap = 120;
      for (int b = 0; b < BUTTONS; b++) begin
         left[b] = $urandom_range(0, 4);
         lvl[b]  = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         for (int b = 0; b < BUTTONS; b++) begin
            if (left[b] == 0) begin
               lvl[b] = !lvl[b];
               if (lvl[b]) begin
                  case ($urandom_range(3))
                     0, 1: begin
                        d = $urandom_range(1, cap);
                     end
                     2: begin
                        d = lp + $urandom_range(0, 2) - 1;
                     end
                     default: begin
                        d = lp + rp * $urandom_range(0, 3) + $urandom_range(0, 1);
                     end
                  endcase
                  if (d < 1) d = 1;
                  if (d > cap) d = cap;
                  left[b] = d;
               end else begin
                  left[b] = $urandom_range(1, 8);
               end
            end
            left[b]--;
            word[b] = lvl[b];
         end
         if ($urandom_range(9) == 0) word = word ^ levels_type'($urandom_range(1, 7));
         push_tick(word);
      end
   endtask

   initial begin : stimulus
      int lp;
      int rp;
      reset = 1'b1;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_LONG_PRESS_TICKS;
      csr_ch.data          = '0;
      send_idle_pct = 15;
      rcv_idle_pct  = 84;
      long_ticks = LONG_PRESS_RESET;
      rep_period = REPEAT_PERIOD_RESET;
      tick_now   = '0;
      for (int b = 0; b < BUTTONS; b++) begin
         press_at[b] = '0;
         held_now[b] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset timing: all down together, partial release, short presses.
      push_tick(3'b000);
      push_hold(3'b111, 2);
      push_tick(3'b101);
      push_tick(3'b000);
      push_tick(3'b010);
      push_tick(3'b000);
      // Zero long press count and zero repeat period: no short, no long.
      set_timing(16'd0, 16'd0);
      push_hold(3'b001, 4);
      push_tick(3'b000);
      // Long press with no further repeats, then a short press.
      set_timing(16'd3, 16'd0);
      push_hold(3'b100, 7);
      push_tick(3'b000);
      push_hold(3'b010, 2);
      push_tick(3'b000);
      // Smallest counts: long on the second tick, repeat on every tick after.
      set_timing(16'd1, 16'd1);
      push_hold(3'b011, 4);
      push_tick(3'b000);
      // Write outside the map, then the largest counts.
      drain_words();
      write_csr(CSR_SPARE, 16'hA5A5);
      set_timing(16'hFFFF, 16'hFFFF);
      push_tick(3'b111);
      push_tick(3'b000);

      for (int phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin lp = 44;    rp = 8;     end
            1: begin lp = 1;     rp = 1;     end
            2: begin lp = 5;     rp = 3;     end
            3: begin lp = 0;     rp = 4;     end
            4: begin lp = 12;    rp = 7;     end
            5: begin lp = 65535; rp = 65535; end
            6: begin lp = 6;     rp = 0;     end
            7: begin lp = 3;     rp = 65535; end
            default: begin
               lp = $urandom_range(1, 30);
               rp = $urandom_range(1, 10);
            end
         endcase
         if (phase == 4) begin
            send_idle_pct = 84;
            rcv_idle_pct  = 15;
         end else if (phase == 8) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         set_timing(lp[CFG_W-1:0], rp[CFG_W-1:0]);
         if (phase == 9) holdoff_go = 1'b1;
         push_button_traffic(PHASE_TICKS);
      end

      drain_words();
      if (mismatch_count == 0) begin
         $display("tb_button_press_classifier_unit: PASS");
      end else begin
         $display("tb_button_press_classifier_unit: FAIL");
      end
      $finish;
   end

endmodule
